/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MM2_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MM2_ASSERT(label, prop, msg) \
	`MM2_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

/* src/mm2_pkg.sv */
// Types and constants of the MurmurHash2 block.
`default_nettype none

package mm2_pkg;

	localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET = 32'd10;

	typedef enum logic [1:0] {
		WK_NONE,
		WK_FULL,
		WK_TAIL
	} word_kind_t;

	typedef enum logic {
		BK_RUN,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		word_kind_t  kind;
		logic        first;
		logic        last;
		logic [31:0] init;
		logic [31:0] value;
	} q_entry_t;

endpackage

`default_nettype wire

/* src/mm2_queue.sv */
// Small FIFO between the word front end and the hash back end.
`default_nettype none

module mm2_queue #(
	parameter int DEPTH = 4,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  mm2_pkg::q_entry_t   push_entry,
	input  wire                 pop,
	output mm2_pkg::q_entry_t   pop_entry,
	output logic                not_empty,
	output logic [CNT_W-1:0]    fill
);
	import mm2_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_pop;

	assign do_pop = pop && (fill_q != '0);
	assign not_empty = (fill_q != '0);
	assign fill = fill_q;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/mm2_front.sv */
// Front end: seed register, word accept, classification and stateless word mix.
`default_nettype none

module mm2_front #(
	parameter int DEPTH = 4,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [31:0]         cfg_wdata,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [31:0]         data_word,
	input  wire  [2:0]          byte_count,
	input  wire                 first_item,
	input  wire                 last_item,
	input  wire  [30:0]         total_length,
	input  wire  [CNT_W-1:0]    fill,
	output logic                push,
	output mm2_pkg::q_entry_t   push_entry
);
	import mm2_pkg::*;

	logic [31:0]    seed_q;
	logic           v_s1;
	logic           v_s2;
	word_kind_t     kind_s1;
	logic           first_s1;
	logic           last_s1;
	logic [31:0]    init_s1;
	logic [31:0]    tail_s1;
	logic [31:0]    prod_s1;
	q_entry_t       entry_s2;

	logic [CNT_W+1:0] busy;
	logic             accept;
	word_kind_t       kind;
	logic [31:0]      tail_mask;
	logic [31:0]      mul1;
	logic [31:0]      kmix;
	logic [31:0]      mul2;

	// words already in flight count against queue space
	assign busy = (CNT_W+2)'(fill) + (CNT_W+2)'(v_s1) + (CNT_W+2)'(v_s2);
	assign in_ready = busy < (CNT_W+2)'(DEPTH);
	assign accept = in_valid && in_ready;

	always_comb begin
		case (byte_count)
			3'd0:    kind = WK_NONE;
			3'd1,
			3'd2,
			3'd3:    kind = WK_TAIL;
			default: kind = WK_FULL;
		endcase
		case (byte_count)
			3'd1:    tail_mask = 32'h0000_00ff;
			3'd2:    tail_mask = 32'h0000_ffff;
			default: tail_mask = 32'h00ff_ffff;
		endcase
	end

	assign mul1 = data_word * MIX_MUL;
	assign kmix = prod_s1 ^ (prod_s1 >> MIX_SHIFT);
	assign mul2 = kmix * MIX_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			first_s1 <= first_item;
			last_s1 <= last_item;
			init_s1 <= seed_q ^ {1'b0, total_length};
			tail_s1 <= data_word & tail_mask;
			prod_s1 <= mul1;
		end
		if (v_s1) begin
			entry_s2.kind <= kind_s1;
			entry_s2.first <= first_s1;
			entry_s2.last <= last_s1;
			entry_s2.init <= init_s1;
			entry_s2.value <= (kind_s1 == WK_FULL) ? mul2 : tail_s1;
		end
	end

	assign push = v_s2;
	assign push_entry = entry_s2;

endmodule

`default_nettype wire

/* src/mm2_back.sv */
// Back end: running hash update, finalization and output register.
`default_nettype none

module mm2_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 not_empty,
	input  mm2_pkg::q_entry_t   pop_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [31:0]         hash_value
);
	import mm2_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] h_q;
	logic [31:0] h_d;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [31:0] h0;
	logic [31:0] mul_a;
	logic [31:0] p;
	logic        fin_load;

	assign h0 = pop_entry.first ? pop_entry.init : h_q;
	assign p = mul_a * MIX_MUL;

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		fin_load = 1'b0;
		h_d = h0;
		mul_a = (pop_entry.kind == WK_TAIL) ? (h0 ^ pop_entry.value) : h0;
		case (state_q)
			BK_RUN: begin
				if (not_empty) begin
					pop = 1'b1;
					case (pop_entry.kind)
						WK_FULL: h_d = p ^ pop_entry.value;
						WK_TAIL: h_d = p;
						default: h_d = h0;
					endcase
					if (pop_entry.last) begin
						state_d = BK_FIN;
					end
				end
			end
			BK_FIN: begin
				mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			h_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				h_q <= h_d;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			hash_q <= p ^ (p >> FIN_SHIFT_B);
		end
	end

	assign out_valid = out_valid_q;
	assign hash_value = hash_q;

endmodule

`default_nettype wire

/* src/murmur2_hash_32.sv */
// A last word goes via s1, s2, the queue, the running hash and BK_FIN to the output register.
// Throughput: one word per cycle when in_ready; a last word holds the multiplier in BK_FIN.
// The back-end multiplier is shared by the hash update and the final mix.
// Reset (arst_n low, async): queue and pipeline empty, running hash 0, seed 10.
// Top level of the 32-bit MurmurHash2 block.
`default_nettype none

module murmur2_hash_32 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [31:0] cfg_wdata,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [31:0] data_word,
	input  wire  [2:0]  byte_count,
	input  wire         first_item,
	input  wire         last_item,
	input  wire  [30:0] total_length,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] hash_value
);
	import mm2_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             push;
	q_entry_t         push_entry;
	logic             pop;
	q_entry_t         pop_entry;
	logic             not_empty;
	logic [CNT_W-1:0] fill;

	mm2_front #(
		.DEPTH(QUEUE_DEPTH),
		.CNT_W(CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.first_item  (first_item),
		.last_item   (last_item),
		.total_length(total_length),
		.fill        (fill),
		.push        (push),
		.push_entry  (push_entry)
	);

	mm2_queue #(
		.DEPTH(QUEUE_DEPTH),
		.CNT_W(CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.not_empty (not_empty),
		.fill      (fill)
	);

	mm2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash_value(hash_value)
	);

endmodule

`default_nettype wire

/* src/mm2_checker.sv */
// Port-level checker for the MurmurHash2 block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mm2_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        last_item,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] hash_value
);

	logic [7:0] pend_q;
	logic       last_acc;
	logic       out_acc;

	assign last_acc = in_valid && in_ready && last_item;
	assign out_acc = out_valid && out_ready;

	// hashes owed: last words taken minus hashes delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_acc, out_acc})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`MM2_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hash_value), "stalled hash dropped or changed")
	`MM2_ASSERT(a_out_owed, out_valid |-> pend_q != 8'd0, "hash offered with no last word outstanding")
	`MM2_ASSERT(a_no_bypass, last_acc && pend_q == 8'd0 && !out_valid |=> !out_valid, "hash appeared one cycle after its last word")

endmodule

bind murmur2_hash_32 mm2_checker u_mm2_checker (.*);

`default_nettype wire

/* tb/sv/murmur2_hash_check.sv */
// Checker for murmur2_hash_32: tracks seed writes and accepted words, predicts hashes, compares.
`timescale 1ns / 1ps

module murmur2_hash_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [31:0] cfg_wdata,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [31:0] data_word,
	input  wire  [2:0]  byte_count,
	input  wire         first_item,
	input  wire         last_item,
	input  wire  [30:0] total_length,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [31:0] hash_value,
	output int          mismatches,
	output int          hashes_waiting,
	output int          hashes_checked
);
	import mm2_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] partial_hash;
	logic [31:0] hash_fifo[$];

	function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] k;
		k = w * MIX_MUL;
		k = k ^ (k >> MIX_SHIFT);
		k = k * MIX_MUL;
		return (h * MIX_MUL) ^ k;
	endfunction

	function automatic logic [31:0] absorb_tail(input logic [31:0] h, input logic [31:0] w,
			input logic [2:0] n);
		logic [31:0] mask;
		case (n)
			3'd1: mask = 32'h0000_00ff;
			3'd2: mask = 32'h0000_ffff;
			default: mask = 32'h00ff_ffff;
		endcase
		return (h ^ (w & mask)) * MIX_MUL;
	endfunction

	function automatic logic [31:0] finalize_hash(input logic [31:0] h);
		logic [31:0] f;
		f = h ^ (h >> FIN_SHIFT_A);
		f = f * MIX_MUL;
		return f ^ (f >> FIN_SHIFT_B);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [31:0] h;
		logic [31:0] want;
		if (!arst_n) begin
			seed_q = SEED_RESET;
			partial_hash = '0;
			hash_fifo.delete();
			mismatches = 0;
			hashes_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				hashes_checked++;
				if (hash_fifo.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected hash %08h at %0t", hash_value, $realtime);
					mismatches++;
				end else begin
					want = hash_fifo.pop_front();
					if (hash_value !== want) begin
						if (mismatches < 10)
							$display("hash mismatch at %0t: expected %08h, got %08h",
								$realtime, want, hash_value);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				seed_q = cfg_wdata;
			if (in_valid && in_ready) begin
				h = first_item ? (seed_q ^ {1'b0, total_length}) : partial_hash;
				if (byte_count >= 3'd4)
					h = absorb_word(h, data_word);
				else if (byte_count != 3'd0)
					h = absorb_tail(h, data_word, byte_count);
				partial_hash = h;
				if (last_item)
					hash_fifo.push_back(finalize_hash(h));
			end
		end
		hashes_waiting = hash_fifo.size();
	end

endmodule

/* tb/sv/tb_murmur2_hash_32.sv */
// Testbench top for murmur2_hash_32: stimulus, seed writes, stalls and verdict.
`timescale 1ns / 1ps

module tb_murmur2_hash_32;
	import mm2_pkg::*;

	localparam int STIM_WORDS = 800;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        first_item = 1'b0;
	logic        last_item = 1'b0;
	logic [30:0] total_length = '0;
	logic        out_ready = 1'b0;
	wire         in_ready;
	wire         out_valid;
	wire  [31:0] hash_value;

	int mismatches;
	int hashes_waiting;
	int hashes_checked;
	int words_sent = 0;
	int messages_sent = 0;
	int seeds_written = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit hold_req = 1'b0;

	murmur2_hash_32 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.byte_count(byte_count),
		.first_item(first_item),
		.last_item(last_item),
		.total_length(total_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_value(hash_value)
	);

	murmur2_hash_check checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.byte_count(byte_count),
		.first_item(first_item),
		.last_item(last_item),
		.total_length(total_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_value(hash_value),
		.mismatches(mismatches),
		.hashes_waiting(hashes_waiting),
		.hashes_checked(hashes_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic f,
			input logic l, input logic [30:0] len);
		int gap;
		gap = tx_idle ? $urandom_range(16, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		byte_count <= n;
		first_item <= f;
		last_item <= l;
		total_length <= len;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic send_message(input int nbytes, input logic [30:0] len);
		int full;
		int rest;
		full = nbytes / 4;
		rest = nbytes % 4;
		if (nbytes == 0) begin
			send_word($urandom, 3'd0, 1'b1, 1'b1, len);
		end else begin
			for (int i = 0; i < full; i++)
				send_word($urandom, 3'd4, i == 0, (i == full - 1) && (rest == 0),
					(i == 0) ? len : 31'($urandom));
			if (rest != 0)
				send_word($urandom, 3'(rest), full == 0, 1'b1,
					(full == 0) ? len : 31'($urandom));
		end
		messages_sent++;
	endtask

	// stop sending and wait until every hash is out and the pipe is quiet
	task automatic drain_hashes();
		in_valid <= 1'b0;
		@(negedge clk);
		while (hashes_waiting != 0) @(negedge clk);
		@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		seeds_written++;
	endtask

	initial begin : receiver
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = rx_idle ? $urandom_range(16, 0) : 0;
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid && !hold_req) @(negedge clk);
			@(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int nbytes;
		logic [30:0] len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset seed, no first word after reset, empty and short messages
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_word(32'habcd_1234, 3'd4, 1'b0, 1'b1, 31'd0);
		send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 31'd0);
		send_word(32'hffff_ff5a, 3'd1, 1'b1, 1'b1, 31'd1);
		send_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
		send_word(32'h0000_0000, 3'd3, 1'b1, 1'b1, 31'd3);
		// oversized counts, ignored word, short word mid-message, max length
		send_word(32'hffff_ffff, 3'd5, 1'b1, 1'b0, 31'h7fff_ffff);
		send_word(32'h0000_0000, 3'd6, 1'b0, 1'b0, 31'h7fff_ffff);
		send_word(32'hdead_beef, 3'd0, 1'b0, 1'b0, 31'd0);
		send_word(32'h1234_5678, 3'd2, 1'b0, 1'b0, 31'd0);
		send_word(32'h8000_0001, 3'd7, 1'b0, 1'b1, 31'd0);
		// continue from the running hash of the previous message
		send_word(32'h1234_5678, 3'd4, 1'b0, 1'b1, 31'h5555_5555);
		send_message(8, 31'd8);
		send_message(7, 31'd7);
		drain_hashes();
		write_seed(32'h0000_0000);
		send_message(0, 31'd0);
		send_message(5, 31'd5);
		drain_hashes();
		write_seed(32'hffff_ffff);
		send_message(0, 31'h7fff_ffff);
		send_message(4, 31'd4);

		phase = 0;
		while (words_sent < STIM_WORDS) begin
			drain_hashes();
			case (phase % 4)
				0: write_seed(32'h0000_0000);
				1: write_seed(32'hffff_ffff);
				default: write_seed($urandom);
			endcase
			tx_idle = $urandom_range(3, 0) != 0;
			rx_idle = $urandom_range(3, 0) != 0;
			if (phase == 1) begin
				// output held off while single-word messages keep coming
				hold_req = 1'b1;
				tx_idle = 1'b0;
				repeat (24) send_word($urandom, 3'd4, 1'b1, 1'b1, 31'($urandom));
				drain_hashes();
				tx_idle = 1'b1;
			end
			repeat ($urandom_range(12, 4)) begin
				if ($urandom_range(99, 0) < 80) begin
					nbytes = ($urandom_range(3, 0) == 0) ? $urandom_range(64, 0)
						: $urandom_range(16, 0);
					len = ($urandom_range(9, 0) == 0) ? 31'($urandom) : 31'(nbytes);
					send_message(nbytes, len);
				end else begin
					repeat ($urandom_range(4, 1))
						send_word($urandom, 3'($urandom_range(7, 0)),
							1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
							31'($urandom));
				end
			end
			phase++;
		end

		drain_hashes();
		$display("Sent %0d words (%0d framed messages plus noise) under %0d seed settings,",
			words_sent, messages_sent, seeds_written);
		$display("checked %0d hashes with random stalls on both sides and one long output hold.",
			hashes_checked);
		if (mismatches == 0 && hashes_waiting == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/mm2_pkg.sv
src/mm2_queue.sv
src/mm2_front.sv
src/mm2_back.sv
src/murmur2_hash_32.sv
src/mm2_checker.sv
tb/sv/murmur2_hash_check.sv
tb/sv/tb_murmur2_hash_32.sv
